// ===== rtl/chkt_pkg.sv =====
// ----------------------------------------------------------------------------
// chkt_pkg
// Shared constants and codes for the chained hash key table.
// ----------------------------------------------------------------------------
package chkt_pkg;

  localparam int BUCKETS_DEF  = 64;
  localparam int POOL_DEF     = 256;
  localparam int KEY_BITS_DEF = 16;

  localparam int KEY_W    = 16;
  localparam int KIND_W   = 2;
  localparam int STATUS_W = 2;
  localparam int HANDLE_W = 8;

  // largest width of one row of the used bitmap memory
  localparam int USED_ROW_MAX = 32;

  localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DELETE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_SEARCH = 2'd2;
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_MISS = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

endpackage

// ===== rtl/chained_hash_key_table_core.sv =====
// Flow: the front end puts an item through its multiply, remainder and queue
//   push steps; the back end then reads the bucket head and walks the chain
//   entries or scans bitmap rows of up to 32 slots, and frees the slot on delete.
// The front end takes no item until the last is pushed; a queue lets it overlap.
// Reset: synchronous; a clearing pass over the bucket heads and bitmap rows
//   empties them, with full held high meanwhile.
// ----------------------------------------------------------------------------
// chained_hash_key_table_core
// Chained hash table of keys with modulo bucket selection.
// ----------------------------------------------------------------------------
module chained_hash_key_table_core #(
  parameter int BUCKETS      = chkt_pkg::BUCKETS_DEF,
  parameter int POOL_ENTRIES = chkt_pkg::POOL_DEF,
  parameter int KEY_BITS     = chkt_pkg::KEY_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_push,
  output logic                            in_full,
  input  logic [chkt_pkg::KIND_W-1:0]     in_kind,
  input  logic [chkt_pkg::KEY_W-1:0]      in_key,
  output logic                            out_empty,
  input  logic                            out_pop,
  output logic [chkt_pkg::STATUS_W-1:0]   out_status,
  output logic [chkt_pkg::HANDLE_W-1:0]   out_handle
);

  localparam int KE   = (KEY_BITS < chkt_pkg::KEY_W) ? KEY_BITS : chkt_pkg::KEY_W;
  localparam int BW   = $clog2(BUCKETS);
  localparam int IW   = chkt_pkg::KIND_W + KE + BW;
  localparam int RESW = chkt_pkg::STATUS_W + chkt_pkg::HANDLE_W;

  logic            clearing;
  logic            item_push;
  logic [IW-1:0]   item_din;
  logic            item_full;
  logic [IW-1:0]   item_dout;
  logic            item_empty;
  logic            item_pop;
  logic            res_push;
  logic [RESW-1:0] res_din;
  logic            res_full;
  logic [RESW-1:0] res_dout;

  chkt_front #(.BUCKETS(BUCKETS), .KEY_BITS(KEY_BITS)) u_front (
    .clk, .rst_n, .in_push, .in_full, .in_kind, .in_key, .clearing,
    .item_push, .item_data(item_din), .item_full
  );

  chkt_fifo #(.W(IW)) u_item_q (
    .clk, .rst_n, .push(item_push), .din(item_din), .full(item_full),
    .pop(item_pop), .dout(item_dout), .empty(item_empty)
  );

  chkt_back #(.BUCKETS(BUCKETS), .POOL_ENTRIES(POOL_ENTRIES), .KEY_BITS(KEY_BITS)) u_back (
    .clk, .rst_n, .clearing, .item_data(item_dout), .item_empty, .item_pop,
    .res_push, .res_data(res_din), .res_full
  );

  chkt_fifo #(.W(RESW)) u_res_q (
    .clk, .rst_n, .push(res_push), .din(res_din), .full(res_full),
    .pop(out_pop), .dout(res_dout), .empty(out_empty)
  );

  assign {out_status, out_handle} = res_dout;

endmodule

// ===== rtl/chkt_fifo.sv =====
// ----------------------------------------------------------------------------
// chkt_fifo
// Two-entry queue that decouples a producer from a consumer.
// ----------------------------------------------------------------------------
module chkt_fifo #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] din,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] dout,
  output logic         empty
);

  logic [W-1:0] data0_r;
  logic [W-1:0] data1_r;
  logic         rd_r;
  logic         wr_r;
  logic [1:0]   cnt_r;
  logic         do_push;
  logic         do_pop;

  assign full    = (cnt_r == 2'd2);
  assign empty   = (cnt_r == 2'd0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = rd_r ? data1_r : data0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_r  <= 1'b0;
      wr_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (do_push) wr_r <= ~wr_r;
      if (do_pop) rd_r <= ~rd_r;
      if (do_push && !do_pop) cnt_r <= cnt_r + 2'd1;
      else if (do_pop && !do_push) cnt_r <= cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push && !wr_r) data0_r <= din;
    if (do_push && wr_r) data1_r <= din;
  end

endmodule

// ===== rtl/chkt_front.sv =====
// ----------------------------------------------------------------------------
// chkt_front
// Accepts operations, masks the key and works out its bucket with a
// reciprocal multiply and a remainder step, then queues the classified item
// for the back end.
// ----------------------------------------------------------------------------
module chkt_front #(
  parameter int BUCKETS  = chkt_pkg::BUCKETS_DEF,
  parameter int KEY_BITS = chkt_pkg::KEY_BITS_DEF,
  localparam int KE = (KEY_BITS < chkt_pkg::KEY_W) ? KEY_BITS : chkt_pkg::KEY_W,
  localparam int BW = $clog2(BUCKETS),
  localparam int IW = chkt_pkg::KIND_W + KE + BW
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_push,
  output logic                          in_full,
  input  logic [chkt_pkg::KIND_W-1:0]   in_kind,
  input  logic [chkt_pkg::KEY_W-1:0]    in_key,
  input  logic                          clearing,
  output logic                          item_push,
  output logic [IW-1:0]                 item_data,
  input  logic                          item_full
);

  localparam int SH = KE + BW;
  localparam int MW = KE + 2;
  // floor(2^SH / BUCKETS) + 1 gives an exact quotient for every KE-bit key
  localparam logic [MW-1:0] RECIP =
    MW'(((longint'(1) << SH) / longint'(BUCKETS)) + longint'(1));
  localparam logic [KE-1:0] DIV_K = KE'(BUCKETS);

  typedef enum logic [1:0] {F_IDLE, F_MUL, F_REM, F_PUSH} fstate_t;

  fstate_t                        state_r;
  logic [chkt_pkg::KIND_W-1:0]    kind_r;
  logic [KE-1:0]                  key_r;
  logic [KE+MW-1:0]               prod_r;
  logic [BW-1:0]                  rem_r;
  logic [KE-1:0]                  quo;
  logic [KE-1:0]                  rem_full;
  logic                           accept;

  assign in_full   = (state_r != F_IDLE) || clearing;
  assign accept    = in_push && !in_full;
  assign item_push = (state_r == F_PUSH);
  assign item_data = {kind_r, key_r, rem_r};

  // remainder wraps at KE bits, which is exact since it never exceeds the key
  assign quo      = KE'(prod_r >> SH);
  assign rem_full = key_r - quo * DIV_K;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      case (state_r)
        F_IDLE: begin
          if (accept) begin
            kind_r  <= in_kind;
            key_r   <= in_key[KE-1:0];
            state_r <= F_MUL;
          end
        end
        F_MUL: begin
          prod_r  <= {{MW{1'b0}}, key_r} * {{KE{1'b0}}, RECIP};
          state_r <= F_REM;
        end
        F_REM: begin
          rem_r   <= BW'(rem_full);
          state_r <= F_PUSH;
        end
        F_PUSH: begin
          if (!item_full) state_r <= F_IDLE;
        end
        default: state_r <= F_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/chkt_back.sv =====
// ----------------------------------------------------------------------------
// chkt_back
// Carries out insert, delete and search on the bucket heads, the entry pool
// and the used bitmap, all held in single-port-read memories; the unused kind gets a miss.
// ----------------------------------------------------------------------------
module chkt_back #(
  parameter int BUCKETS      = chkt_pkg::BUCKETS_DEF,
  parameter int POOL_ENTRIES = chkt_pkg::POOL_DEF,
  parameter int KEY_BITS     = chkt_pkg::KEY_BITS_DEF,
  localparam int KE = (KEY_BITS < chkt_pkg::KEY_W) ? KEY_BITS : chkt_pkg::KEY_W,
  localparam int BW = $clog2(BUCKETS),
  localparam int IW = chkt_pkg::KIND_W + KE + BW,
  localparam int RESW = chkt_pkg::STATUS_W + chkt_pkg::HANDLE_W
) (
  input  logic            clk,
  input  logic            rst_n,
  output logic            clearing,
  input  logic [IW-1:0]   item_data,
  input  logic            item_empty,
  output logic            item_pop,
  output logic            res_push,
  output logic [RESW-1:0] res_data,
  input  logic            res_full
);

  localparam int PW    = $clog2(POOL_ENTRIES);
  localparam int LW    = $clog2(POOL_ENTRIES + 1);
  localparam int UW    = (POOL_ENTRIES >= chkt_pkg::USED_ROW_MAX) ?
                         chkt_pkg::USED_ROW_MAX : (1 << $clog2(POOL_ENTRIES));
  localparam int UWB   = $clog2(UW);
  localparam int UROWS = (POOL_ENTRIES + UW - 1) / UW;
  localparam int RW    = (UROWS > 1) ? $clog2(UROWS) : 1;
  localparam int SW    = RW + UWB;
  localparam int CLR_N = (BUCKETS > UROWS) ? BUCKETS : UROWS;
  localparam int CW    = $clog2(CLR_N + 1);
  localparam logic [LW-1:0] EMPTY_MARK = LW'(POOL_ENTRIES);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_HEAD, S_URD, S_UCHK, S_ERD, S_ECHK, S_DURD, S_DUCHK, S_RESP
  } bstate_t;

  bstate_t                         state_r;
  logic [chkt_pkg::KIND_W-1:0]     kind_r;
  logic [KE-1:0]                   key_r;
  logic [BW-1:0]                   bkt_r;
  logic [LW-1:0]                   head_r;
  logic [LW-1:0]                   cur_r;
  logic [LW-1:0]                   prev_r;
  logic [LW-1:0]                   steps_r;
  logic [RW-1:0]                   row_r;
  logic [CW-1:0]                   clr_r;
  logic [chkt_pkg::STATUS_W-1:0]   res_st_r;
  logic [PW-1:0]                   res_h_r;

  logic [LW-1:0] head_mem [BUCKETS];
  logic [KE-1:0] key_mem  [POOL_ENTRIES];
  logic [LW-1:0] link_mem [POOL_ENTRIES];
  logic [UW-1:0] used_mem [UROWS];

  logic [LW-1:0] head_q;
  logic [KE-1:0] key_q;
  logic [LW-1:0] link_q;
  logic [UW-1:0] used_q;

  logic [chkt_pkg::KIND_W-1:0] in_kind;
  logic [KE-1:0]               in_key;
  logic [BW-1:0]               in_bkt;
  logic [PW-1:0]               cur_idx;
  logic [RW-1:0]               cur_row;
  logic [UWB-1:0]              cur_bit;
  logic [RW-1:0]               used_ra;
  logic [UWB-1:0]              pe;
  logic                        found;
  logic [SW-1:0]               slot_w;
  logic [PW-1:0]               slot;
  logic [UW-1:0]               pad;
  logic                        clr_act;
  logic                        ins_wr;
  logic                        hit;
  logic                        del_unlink;
  logic                        del_free;

  assign {in_kind, in_key, in_bkt} = item_data;
  assign clearing  = (state_r == S_CLEAR);
  assign item_pop  = (state_r == S_IDLE) && !item_empty;
  assign res_push  = (state_r == S_RESP);
  assign res_data  = {res_st_r, chkt_pkg::HANDLE_W'(res_h_r)};

  assign cur_idx   = cur_r[PW-1:0];
  assign cur_row   = RW'(cur_idx >> UWB);
  assign cur_bit   = cur_r[UWB-1:0];
  assign used_ra   = (state_r == S_DURD) ? cur_row : row_r;

  // lowest free slot in the row just read
  always_comb begin
    pe = '0;
    for (int i = UW - 1; i >= 0; i--) begin
      if (!used_q[i]) pe = UWB'(i);
    end
  end
  assign found  = ~&used_q;
  assign slot_w = {row_r, pe};
  assign slot   = PW'(slot_w);

  // slots past the pool in the last row read as taken
  always_comb begin
    for (int b = 0; b < UW; b++) begin
      pad[b] = ((int'(clr_r) * UW + b) >= POOL_ENTRIES);
    end
  end

  assign clr_act    = (state_r == S_CLEAR);
  assign ins_wr     = (state_r == S_UCHK) && found;
  assign hit        = (state_r == S_ECHK) && (key_q == key_r);
  assign del_unlink = hit && (kind_r == chkt_pkg::KIND_DELETE);
  assign del_free   = (state_r == S_DUCHK);

  // bucket heads
  always_ff @(posedge clk) begin
    if (clr_act && (int'(clr_r) < BUCKETS)) head_mem[BW'(clr_r)] <= EMPTY_MARK;
    else if (ins_wr) head_mem[bkt_r] <= LW'(slot);
    else if (del_unlink && (prev_r == EMPTY_MARK)) head_mem[bkt_r] <= link_q;
    head_q <= head_mem[in_bkt];
  end

  // entry keys and links
  always_ff @(posedge clk) begin
    if (ins_wr) key_mem[slot] <= key_r;
    key_q <= key_mem[cur_idx];
  end

  always_ff @(posedge clk) begin
    if (ins_wr) link_mem[slot] <= head_r;
    else if (del_unlink && (prev_r != EMPTY_MARK)) link_mem[prev_r[PW-1:0]] <= link_q;
    link_q <= link_mem[cur_idx];
  end

  // used bitmap
  always_ff @(posedge clk) begin
    if (clr_act && (int'(clr_r) < UROWS)) used_mem[RW'(clr_r)] <= pad;
    else if (ins_wr) used_mem[row_r] <= used_q | (UW'(1) << pe);
    else if (del_free) used_mem[cur_row] <= used_q & ~(UW'(1) << cur_bit);
    used_q <= used_mem[used_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r   <= '0;
    end else begin
      case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + CW'(1);
          if (clr_r == CW'(CLR_N - 1)) state_r <= S_IDLE;
        end
        S_IDLE: begin
          if (!item_empty) begin
            kind_r <= in_kind;
            key_r  <= in_key;
            bkt_r  <= in_bkt;
            if (in_kind == chkt_pkg::KIND_INSERT || in_kind == chkt_pkg::KIND_DELETE ||
                in_kind == chkt_pkg::KIND_SEARCH) begin
              state_r <= S_HEAD;
            end else begin
              res_st_r <= chkt_pkg::ST_MISS;
              res_h_r  <= '0;
              state_r  <= S_RESP;
            end
          end
        end
        S_HEAD: begin
          head_r  <= head_q;
          cur_r   <= head_q;
          prev_r  <= EMPTY_MARK;
          steps_r <= '0;
          row_r   <= '0;
          if (kind_r == chkt_pkg::KIND_INSERT) state_r <= S_URD;
          else state_r <= S_ERD;
        end
        S_URD: state_r <= S_UCHK;
        S_UCHK: begin
          if (found) begin
            res_st_r <= chkt_pkg::ST_OK;
            res_h_r  <= slot;
            state_r  <= S_RESP;
          end else if (row_r == RW'(UROWS - 1)) begin
            res_st_r <= chkt_pkg::ST_FULL;
            res_h_r  <= '0;
            state_r  <= S_RESP;
          end else begin
            row_r   <= row_r + RW'(1);
            state_r <= S_URD;
          end
        end
        S_ERD: begin
          if (cur_r >= EMPTY_MARK || steps_r == EMPTY_MARK) begin
            res_st_r <= chkt_pkg::ST_MISS;
            res_h_r  <= '0;
            state_r  <= S_RESP;
          end else begin
            state_r <= S_ECHK;
          end
        end
        S_ECHK: begin
          if (hit) begin
            res_st_r <= chkt_pkg::ST_OK;
            res_h_r  <= cur_idx;
            if (kind_r == chkt_pkg::KIND_DELETE) state_r <= S_DURD;
            else state_r <= S_RESP;
          end else begin
            prev_r  <= cur_r;
            cur_r   <= link_q;
            steps_r <= steps_r + LW'(1);
            state_r <= S_ERD;
          end
        end
        S_DURD:  state_r <= S_DUCHK;
        S_DUCHK: state_r <= S_RESP;
        S_RESP: begin
          if (!res_full) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/chkt_checker.sv =====
// ----------------------------------------------------------------------------
// chkt_checker
// Port-level checks for the chained hash key table.
// ----------------------------------------------------------------------------
module chkt_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_push,
  input logic                          in_full,
  input logic                          out_empty,
  input logic                          out_pop,
  input logic [chkt_pkg::STATUS_W-1:0] out_status,
  input logic [chkt_pkg::HANDLE_W-1:0] out_handle
);

  // reset leaves no result and blocks input for the clearing pass
  a_rst: assert property (@(posedge clk) !rst_n |=> (out_empty && in_full))
    else $error("result pending or input open right after reset");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_push && !in_full) |=> in_full)
    else $error("input still open after an accepted beat");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_status != chkt_pkg::ST_OK) |-> (out_handle == '0))
    else $error("nonzero handle on a failed operation");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> (out_status == chkt_pkg::ST_OK || out_status == chkt_pkg::ST_MISS ||
                     out_status == chkt_pkg::ST_FULL))
    else $error("undefined status code");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_status) && $stable(out_handle)))
    else $error("waiting result changed");

endmodule

bind chained_hash_key_table_core chkt_checker u_chkt_checker (.*);
